// ----- rtl/cabfp_pkg.sv -----
// Shared types and constants for the carbon-aware best-fit placer.
// Request/result structs, request codes and the search token of the cell chain.
// No dependencies.
`default_nettype none

package cabfp_pkg;

  localparam int REQ_W     = 2;
  localparam int SLOT_W    = 6;
  localparam int DC_W      = 2;
  localparam int COMPUTE_W = 24;
  localparam int MEMORY_W  = 20;
  localparam int CARBON_W  = 16;
  localparam int TAG_W     = 16;

  // datacenter numbers a request can carry
  localparam int DC_NUM = 1 << DC_W;

  localparam logic [REQ_W-1:0] REQ_HOST   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CARBON = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PLACE  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]     req_type;
    logic [SLOT_W-1:0]    host_slot;
    logic [DC_W-1:0]      dc_number;
    logic                 host_active;
    logic [COMPUTE_W-1:0] compute_amount;
    logic [MEMORY_W-1:0]  memory_amount;
    logic [CARBON_W-1:0]  carbon_value;
    logic [TAG_W-1:0]     job_tag;
  } req_t;

  typedef struct packed {
    logic              placed;
    logic [TAG_W-1:0]  job_tag_out;
    logic [SLOT_W-1:0] chosen_host;
  } res_t;

  // running best candidate passed from cell to cell
  typedef struct packed {
    logic                 found;
    logic [CARBON_W-1:0]  carbon;
    logic [DC_W-1:0]      dc;
    logic [COMPUTE_W-1:0] slack;
    logic [SLOT_W-1:0]    idx;
  } tok_t;

  typedef struct packed {
    logic ld;    // write this slot from the request
    logic sub;   // subtract the job demand
    logic scan;  // search token advances
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/cabfp_cell.sv -----
// One host slot of the placer chain: slot state plus one candidate compare.
// Takes the running best token from its left neighbor, registers it onward.
// Depends on cabfp_pkg.
`default_nettype none

module cabfp_cell #(
  parameter int DC_COUNT = 4,
  parameter int CARB_N   = 4,
  parameter int IDX      = 0
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire cabfp_pkg::cell_ctl_t                  ctl,
  input  wire logic [cabfp_pkg::DC_W-1:0]            ld_dc,
  input  wire logic                                  ld_active,
  input  wire logic [cabfp_pkg::COMPUTE_W-1:0]       ld_compute,
  input  wire logic [cabfp_pkg::MEMORY_W-1:0]        ld_memory,
  input  wire logic [cabfp_pkg::COMPUTE_W-1:0]       dem_compute,
  input  wire logic [cabfp_pkg::MEMORY_W-1:0]        dem_memory,
  input  wire logic [CARB_N-1:0][cabfp_pkg::CARBON_W-1:0] carb,
  input  wire cabfp_pkg::tok_t                       tok_in,
  output cabfp_pkg::tok_t                            tok_out
);

  localparam logic [31:0] IDX_VEC = 32'(IDX);
  localparam logic [cabfp_pkg::SLOT_W-1:0] MY_IDX = IDX_VEC[cabfp_pkg::SLOT_W-1:0];

  logic                              usable_r;
  logic [cabfp_pkg::DC_W-1:0]        dc_r;
  logic [cabfp_pkg::COMPUTE_W-1:0]   comp_r;
  logic [cabfp_pkg::MEMORY_W-1:0]    mem_r;
  cabfp_pkg::tok_t                   tok_r;
  cabfp_pkg::tok_t                   tok_nxt;

  logic [cabfp_pkg::CARBON_W-1:0]    my_carb;
  logic [cabfp_pkg::COMPUTE_W-1:0]   slack;
  logic                              fits;
  logic                              better;

  always_comb begin
    my_carb = '0;
    for (int k = 0; k < CARB_N; k++) begin
      if (dc_r == cabfp_pkg::DC_W'(k)) begin
        my_carb = carb[k];
      end
    end
  end

  assign slack = comp_r - dem_compute;
  assign fits  = usable_r && (32'(dc_r) < 32'(DC_COUNT)) &&
                 (comp_r >= dem_compute) && (mem_r >= dem_memory);
  assign better = !tok_in.found || (my_carb < tok_in.carbon) ||
                  ((my_carb == tok_in.carbon) && ((dc_r < tok_in.dc) ||
                   ((dc_r == tok_in.dc) && (slack < tok_in.slack))));

  always_comb begin
    tok_nxt = tok_in;
    if (fits && better) begin
      tok_nxt.found  = 1'b1;
      tok_nxt.carbon = my_carb;
      tok_nxt.dc     = dc_r;
      tok_nxt.slack  = slack;
      tok_nxt.idx    = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usable_r <= 1'b0;
    end else if (ctl.ld) begin
      usable_r <= ld_active;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      dc_r   <= ld_dc;
      comp_r <= ld_compute;
      mem_r  <= ld_memory;
    end else if (ctl.sub) begin
      comp_r <= comp_r - dem_compute;
      mem_r  <= mem_r - dem_memory;
    end
    if (ctl.scan) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

// ----- rtl/carbon_aware_best_fit_placer_unit.sv -----
// Top level of the carbon-aware best-fit placer: request decode, carbon table,
// scan sequencer, result register and the chain of host slot cells.
// Depends on cabfp_pkg and cabfp_cell.
`default_nettype none

// One request at a time. A placement walks the search token down the cell chain,
// one host slot per cycle. The result register lets a new request be accepted
// while the previous result is still stalled.
// Ties on carbon go to the lower datacenter, then the least compute slack,
// then the lower slot. No clearing pass after reset.
module carbon_aware_best_fit_placer_unit #(
  parameter int HOST_SLOTS = 64,
  parameter int DC_COUNT   = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire cabfp_pkg::req_t in_req,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output cabfp_pkg::res_t      out_res
);

  localparam int CNT_W  = $clog2(HOST_SLOTS);
  localparam int ADDR_W = (CNT_W > cabfp_pkg::SLOT_W) ? CNT_W : cabfp_pkg::SLOT_W;
  localparam int CARB_N = (DC_COUNT < cabfp_pkg::DC_NUM) ? DC_COUNT : cabfp_pkg::DC_NUM;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                             state_r, state_nxt;
  logic [CNT_W-1:0]                       cnt_r, cnt_nxt;
  logic                                   is_place_r;
  logic [cabfp_pkg::COMPUTE_W-1:0]        job_comp_r;
  logic [cabfp_pkg::MEMORY_W-1:0]         job_mem_r;
  logic [cabfp_pkg::TAG_W-1:0]            job_tag_r;
  logic [CARB_N-1:0][cabfp_pkg::CARBON_W-1:0] carb_r;
  logic                                   out_valid_r, out_valid_nxt;
  cabfp_pkg::res_t                        out_res_r;

  logic                                   accept;
  logic                                   ld_host;
  logic                                   ld_carbon;
  logic                                   is_place;
  logic                                   fin_fire;
  logic                                   sub_fire;
  cabfp_pkg::tok_t                        best;
  cabfp_pkg::tok_t                        tok_empty;
  cabfp_pkg::tok_t                        chain [HOST_SLOTS+1];
  logic [HOST_SLOTS-1:0]                  sub_hit;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    ld_host   = 1'b0;
    ld_carbon = 1'b0;
    is_place  = 1'b0;
    unique case (in_req.req_type)
      cabfp_pkg::REQ_HOST:   ld_host   = accept;
      cabfp_pkg::REQ_CARBON: ld_carbon = accept;
      cabfp_pkg::REQ_PLACE:  is_place  = 1'b1;
      default: ;
    endcase
  end

  assign best     = chain[HOST_SLOTS];
  assign fin_fire = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);
  assign sub_fire = fin_fire && is_place_r && best.found;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = is_place ? ST_SCAN : ST_FINISH;
          cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(HOST_SLOTS - 1)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_place_r <= is_place;
      job_comp_r <= in_req.compute_amount;
      job_mem_r  <= in_req.memory_amount;
      job_tag_r  <= in_req.job_tag;
    end
    if (ld_carbon) begin
      for (int k = 0; k < CARB_N; k++) begin
        if (in_req.dc_number == cabfp_pkg::DC_W'(k)) begin
          carb_r[k] <= in_req.carbon_value;
        end
      end
    end
    if (fin_fire) begin
      out_res_r.placed      <= sub_fire;
      out_res_r.job_tag_out <= is_place_r ? job_tag_r : '0;
      out_res_r.chosen_host <= sub_fire ? best.idx : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    tok_empty = '0;
  end
  assign chain[0] = tok_empty;

  for (genvar g = 0; g < HOST_SLOTS; g++) begin : g_cell
    cabfp_pkg::cell_ctl_t ctl;
    assign sub_hit[g] = sub_fire && (ADDR_W'(best.idx) == ADDR_W'(g));
    assign ctl.ld     = ld_host && (ADDR_W'(in_req.host_slot) == ADDR_W'(g));
    assign ctl.sub    = sub_hit[g];
    assign ctl.scan   = (state_r == ST_SCAN);

    cabfp_cell #(
      .DC_COUNT (DC_COUNT),
      .CARB_N   (CARB_N),
      .IDX      (g)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .ld_dc       (in_req.dc_number),
      .ld_active   (in_req.host_active),
      .ld_compute  (in_req.compute_amount),
      .ld_memory   (in_req.memory_amount),
      .dem_compute (job_comp_r),
      .dem_memory  (job_mem_r),
      .carb        (carb_r),
      .tok_in      (chain[g]),
      .tok_out     (chain[g+1])
    );
  end

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && cnt_r == CNT_W'(HOST_SLOTS - 1)) |=> state_r == ST_FINISH)
    else $error("scan did not end after the last cell");

  a_place_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_place) |=> (state_r == ST_SCAN && cnt_r == '0))
    else $error("placement did not start a scan");

  a_load_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_place) |=> state_r == ST_FINISH)
    else $error("load request did not go to finish");

  a_one_sub: assert property (@(posedge clk) disable iff (!rst_n)
    sub_fire ? $onehot(sub_hit) : (sub_hit == '0))
    else $error("demand subtracted from other than one slot");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    sub_fire |-> (32'(best.idx) < 32'(HOST_SLOTS)))
    else $error("chosen slot beyond the table");

endmodule

`default_nettype wire

// ----- verif/carbon_aware_best_fit_placer_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for carbon_aware_best_fit_placer_unit: directed rows, then random
// host loads, carbon loads and job placements checked against an in-bench placement predictor.
// Depends on cabfp_pkg and the placer RTL.

module carbon_aware_best_fit_placer_unit_tb;

  localparam int HOST_SLOTS = 64;
  localparam int DC_COUNT = 4;
  localparam logic [cabfp_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int LONG_HOLD_CYCLES = 700;
  localparam int DRAIN_CYCLES = HOST_SLOTS + 8;

  typedef struct {
    cabfp_pkg::req_t req;
    bit              typed;
    cabfp_pkg::res_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  cabfp_pkg::req_t in_req;
  logic out_valid;
  logic out_stall;
  cabfp_pkg::res_t out_res;

  // predictor state
  logic                            host_on      [HOST_SLOTS];
  logic [cabfp_pkg::DC_W-1:0]      host_dc      [HOST_SLOTS];
  logic [cabfp_pkg::COMPUTE_W-1:0] host_cpu     [HOST_SLOTS];
  logic [cabfp_pkg::MEMORY_W-1:0]  host_mem     [HOST_SLOTS];
  logic [cabfp_pkg::CARBON_W-1:0]  dc_intensity [cabfp_pkg::DC_NUM];

  cabfp_pkg::res_t awaited_results[$];
  dir_row_t        directed_rows[$];

  int mismatch_count = 0;
  int results_seen = 0;
  int n_place = 0, n_placed = 0, n_nofit = 0, n_host = 0, n_carbon = 0, n_unused = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_now = 1'b0;
  int long_holds_done = 0;

  carbon_aware_best_fit_placer_unit #(
    .HOST_SLOTS(HOST_SLOTS),
    .DC_COUNT(DC_COUNT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res(out_res)
  );

  always #5 clk = ~clk;

  task automatic note_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Applies one request to the predictor state and returns the result it must produce.
  function automatic cabfp_pkg::res_t placement_outcome(input cabfp_pkg::req_t r);
    cabfp_pkg::res_t                 o;
    logic                            hit;
    logic [cabfp_pkg::SLOT_W-1:0]    pick;
    logic [cabfp_pkg::CARBON_W-1:0]  pick_carbon;
    logic [cabfp_pkg::DC_W-1:0]      pick_dc;
    logic [cabfp_pkg::COMPUTE_W-1:0] pick_slack;
    logic [cabfp_pkg::CARBON_W-1:0]  hc;
    logic [cabfp_pkg::COMPUTE_W-1:0] slack;
    o = '0;
    case (r.req_type)
      cabfp_pkg::REQ_HOST: begin
        host_on[r.host_slot] = r.host_active;
        host_dc[r.host_slot] = r.dc_number;
        host_cpu[r.host_slot] = r.compute_amount;
        host_mem[r.host_slot] = r.memory_amount;
        n_host++;
      end
      cabfp_pkg::REQ_CARBON: begin
        dc_intensity[r.dc_number] = r.carbon_value;
        n_carbon++;
      end
      cabfp_pkg::REQ_PLACE: begin
        hit = 1'b0;
        pick = '0;
        pick_carbon = '0;
        pick_dc = '0;
        pick_slack = '0;
        for (int i = 0; i < HOST_SLOTS; i++) begin
          if (host_on[i] && host_cpu[i] >= r.compute_amount
              && host_mem[i] >= r.memory_amount) begin
            hc = dc_intensity[host_dc[i]];
            slack = host_cpu[i] - r.compute_amount;
            if (!hit || hc < pick_carbon || (hc == pick_carbon && (host_dc[i] < pick_dc ||
                (host_dc[i] == pick_dc && slack < pick_slack)))) begin
              hit = 1'b1;
              pick = cabfp_pkg::SLOT_W'(i);
              pick_carbon = hc;
              pick_dc = host_dc[i];
              pick_slack = slack;
            end
          end
        end
        o.job_tag_out = r.job_tag;
        n_place++;
        if (hit) begin
          host_cpu[pick] = host_cpu[pick] - r.compute_amount;
          host_mem[pick] = host_mem[pick] - r.memory_amount;
          o.placed = 1'b1;
          o.chosen_host = pick;
          n_placed++;
        end else begin
          n_nofit++;
        end
      end
      default: begin
        n_unused++;
      end
    endcase
    return o;
  endfunction

  function automatic cabfp_pkg::req_t mk_host(input int slot, input int dcn, input bit act,
                                              input int unsigned cpu, input int unsigned mem);
    cabfp_pkg::req_t r;
    r = '0;
    r.req_type = cabfp_pkg::REQ_HOST;
    r.host_slot = cabfp_pkg::SLOT_W'(slot);
    r.dc_number = cabfp_pkg::DC_W'(dcn);
    r.host_active = act;
    r.compute_amount = cabfp_pkg::COMPUTE_W'(cpu);
    r.memory_amount = cabfp_pkg::MEMORY_W'(mem);
    return r;
  endfunction

  function automatic cabfp_pkg::req_t mk_carbon(input int dcn, input int unsigned c);
    cabfp_pkg::req_t r;
    r = '0;
    r.req_type = cabfp_pkg::REQ_CARBON;
    r.dc_number = cabfp_pkg::DC_W'(dcn);
    r.carbon_value = cabfp_pkg::CARBON_W'(c);
    return r;
  endfunction

  function automatic cabfp_pkg::req_t mk_place(input int unsigned cpu, input int unsigned mem,
                                               input int unsigned tag);
    cabfp_pkg::req_t r;
    r = '0;
    r.req_type = cabfp_pkg::REQ_PLACE;
    r.compute_amount = cabfp_pkg::COMPUTE_W'(cpu);
    r.memory_amount = cabfp_pkg::MEMORY_W'(mem);
    r.job_tag = cabfp_pkg::TAG_W'(tag);
    return r;
  endfunction

  function automatic cabfp_pkg::res_t mk_res(input bit placed, input int unsigned tag,
                                             input int slot);
    cabfp_pkg::res_t o;
    o.placed = placed;
    o.job_tag_out = cabfp_pkg::TAG_W'(tag);
    o.chosen_host = cabfp_pkg::SLOT_W'(slot);
    return o;
  endfunction

  task automatic add_row(input cabfp_pkg::req_t r, input bit typed, input cabfp_pkg::res_t want);
    dir_row_t row;
    row.req = r;
    row.typed = typed;
    row.want = want;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  function automatic int unsigned draw_amount(input int unsigned top, input bit is_demand);
    case ($urandom_range(0, 4))
      0: return is_demand ? 0 : top;
      1: return $urandom_range(0, 15) << 4;
      2: return $urandom_range(0, 4095);
      3: return $urandom_range(0, top);
      default: return is_demand ? top : $urandom_range(0, top);
    endcase
  endfunction

  function automatic cabfp_pkg::req_t random_request();
    cabfp_pkg::req_t r;
    int              pick;
    r.host_slot = cabfp_pkg::SLOT_W'($urandom_range(0, HOST_SLOTS - 1));
    r.dc_number = cabfp_pkg::DC_W'($urandom_range(0, cabfp_pkg::DC_NUM - 1));
    r.host_active = ($urandom_range(0, 9) != 0);
    r.compute_amount = cabfp_pkg::COMPUTE_W'($urandom_range(0, 24'hFFFFFF));
    r.memory_amount = cabfp_pkg::MEMORY_W'($urandom_range(0, 20'hFFFFF));
    r.carbon_value = cabfp_pkg::CARBON_W'($urandom_range(0, 16'hFFFF));
    r.job_tag = cabfp_pkg::TAG_W'($urandom_range(0, 16'hFFFF));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      r.req_type = cabfp_pkg::REQ_HOST;
      r.compute_amount = cabfp_pkg::COMPUTE_W'(draw_amount(24'hFFFFFF, 1'b0));
      r.memory_amount = cabfp_pkg::MEMORY_W'(draw_amount(20'hFFFFF, 1'b0));
    end else if (pick < 38) begin
      r.req_type = cabfp_pkg::REQ_CARBON;
      // narrow values force carbon ties between datacenters
      if ($urandom_range(0, 1) == 0) r.carbon_value = cabfp_pkg::CARBON_W'($urandom_range(0, 3));
    end else if (pick < 98) begin
      r.req_type = cabfp_pkg::REQ_PLACE;
      r.compute_amount = cabfp_pkg::COMPUTE_W'(draw_amount(24'hFFFFFF, 1'b1));
      r.memory_amount = cabfp_pkg::MEMORY_W'(draw_amount(20'hFFFFF, 1'b1));
    end else begin
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  task automatic offer(input cabfp_pkg::req_t r, input bit typed, input cabfp_pkg::res_t want);
    cabfp_pkg::res_t predicted;
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (in_stall);
    predicted = placement_outcome(r);
    awaited_results.insert(awaited_results.size(), typed ? want : predicted);
  endtask

  task automatic maybe_gap();
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic run_random(input int count, input bit vary_idle);
    for (int k = 0; k < count; k++) begin
      if (vary_idle && k % 64 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      offer(random_request(), 1'b0, '0);
      maybe_gap();
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall bursts plus one long hold-off on request
  initial begin : receiver
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_now) begin
        hold_now = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        long_holds_done++;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    cabfp_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result %h", out_res));
      end else begin
        want = awaited_results.pop_front();
        results_seen++;
        if (out_res.placed !== want.placed)
          note_mismatch($sformatf("result %0d placed %b, want %b",
                                  results_seen, out_res.placed, want.placed));
        if (out_res.job_tag_out !== want.job_tag_out)
          note_mismatch($sformatf("result %0d job_tag_out %h, want %h",
                                  results_seen, out_res.job_tag_out, want.job_tag_out));
        if (out_res.chosen_host !== want.chosen_host)
          note_mismatch($sformatf("result %0d chosen_host %0d, want %0d",
                                  results_seen, out_res.chosen_host, want.chosen_host));
      end
    end
  end

  initial begin : stimulus
    cabfp_pkg::req_t r;
    for (int i = 0; i < HOST_SLOTS; i++) host_on[i] = 1'b0;
    in_valid <= 1'b0;
    in_req <= '0;
    rst_n <= 1'b0;

    add_row(mk_place(0, 0, 16'hFFFF), 1'b1, mk_res(1'b0, 16'hFFFF, 0));
    r = '1;
    r.req_type = REQ_UNUSED;
    add_row(r, 1'b1, '0);
    add_row(mk_carbon(0, 100), 1'b1, '0);
    add_row(mk_carbon(1, 50), 1'b1, '0);
    add_row(mk_carbon(2, 50), 1'b1, '0);
    add_row(mk_carbon(3, 16'hFFFF), 1'b1, '0);
    r = mk_host(63, 3, 1'b1, 24'hFFFFFF, 20'hFFFFF);
    r.job_tag = '1;
    r.carbon_value = '1;
    add_row(r, 1'b1, '0);
    add_row(mk_host(0, 1, 1'b1, 1000, 1000), 1'b1, '0);
    add_row(mk_host(1, 2, 1'b1, 1000, 1000), 1'b1, '0);
    add_row(mk_host(2, 1, 1'b1, 500, 1000), 1'b1, '0);
    add_row(mk_host(3, 1, 1'b0, 24'hFFFFFF, 20'hFFFFF), 1'b1, '0);
    // carbon tie dc1/dc2 -> lower dc, then least slack
    add_row(mk_place(400, 10, 16'h0001), 1'b0, '0);
    add_row(mk_place(0, 0, 16'h0002), 1'b0, '0);
    add_row(mk_place(24'hFFFFFF, 20'hFFFFF, 16'h8000), 1'b1, mk_res(1'b1, 16'h8000, 63));
    add_row(mk_place(24'hFFFFFF, 20'hFFFFF, 16'h7FFF), 1'b1, mk_res(1'b0, 16'h7FFF, 0));
    add_row(mk_carbon(1, 0), 1'b1, '0);
    add_row(mk_host(5, 1, 1'b1, 1000, 1000), 1'b1, '0);
    // equal slack -> lower slot
    add_row(mk_place(1000, 1000, 16'h0003), 1'b0, '0);
    add_row(mk_carbon(2, 0), 1'b1, '0);
    add_row(mk_place(1000, 1000, 16'h0004), 1'b0, '0);
    add_row(mk_host(3, 0, 1'b1, 10, 10), 1'b1, '0);
    add_row(mk_place(5, 5, 16'h0005), 1'b0, '0);
    add_row(mk_place(1, 20'hFFFFF, 16'h0006), 1'b0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      maybe_gap();
    end

    run_random(900, 1'b1);

    // long receiver hold-off while requests keep coming
    tx_idle_on = 1'b0;
    hold_now = 1'b1;
    for (int k = 0; k < 30; k++) offer(random_request(), 1'b0, '0);
    wait_drained();

    run_random(700, 1'b1);

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random(295, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d results: %0d placements (%0d placed, %0d no fit), %0d host loads,",
             results_seen, n_place, n_placed, n_nofit, n_host);
    $display("  %0d carbon loads, %0d unused-type requests, %0d long output hold-off(s).",
             n_carbon, n_unused, long_holds_done);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #15000000;
    $display("Timeout with %0d results outstanding", awaited_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cabfp_pkg.sv
rtl/cabfp_cell.sv
rtl/carbon_aware_best_fit_placer_unit.sv
verif/carbon_aware_best_fit_placer_unit_tb.sv
